@@ rtl/fpdm_pkg.sv @@
`default_nettype none

package fpdm_pkg;

   localparam int MAX_PWM_BITS_DEF = 16;

   localparam int PCT_W  = 7;
   localparam int DUTY_W = 16;

   localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

   // command codes
   localparam logic [1:0] OP_SET_BRIGHT = 2'd0;
   localparam logic [1:0] OP_SET_MIX    = 2'd1;
   localparam logic [1:0] OP_OFF        = 2'd2;
   localparam logic [1:0] OP_ON         = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_PWM_BITS     = 2'd0;
   localparam logic [1:0] CSR_ACTIVE_HIGH  = 2'd1;
   localparam logic [1:0] CSR_DUAL_CHANNEL = 2'd2;
   localparam logic [1:0] CSR_PERCEPTUAL   = 2'd3;

   localparam logic [4:0] PWM_BITS_RST = 5'd10;
   localparam logic [PCT_W-1:0] REMEMBERED_RST = 7'd100;

   // divide by 100: every numerator on this path is below 2^23, and
   // (x * ceil(2^30 / 100)) >> 30 is exact there
   localparam int          PCT_NUM_W   = 23;
   localparam int          RECIP_W     = 24;
   localparam int          RECIP_SHIFT = 30;
   localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

   // divide by 65535: high half plus a correction of 0..2
   localparam logic [DUTY_W:0] DIV_FULL_ONE = 17'd65535;
   localparam logic [DUTY_W:0] DIV_FULL_TWO = 17'd131070;

   localparam logic [DUTY_W-1:0] ROUND_GAMMA = 16'd32767;
   localparam logic [DUTY_W-1:0] ROUND_PCT   = 16'd50;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PCT_COOL,
      ST_PCT_WARM,
      ST_DUTY_COOL,
      ST_DUTY_WARM,
      ST_GAMMA,
      ST_SPLIT,
      ST_DONE
   } fpdm_state_type;

   // (a * b + addend) / 65535 when by_full, else / 100
   typedef struct packed {
      logic              start;
      logic              by_full;
      logic [DUTY_W-1:0] a;
      logic [DUTY_W-1:0] b;
      logic [DUTY_W-1:0] addend;
   } div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [DUTY_W-1:0] quotient;
   } div_rsp_type;

   localparam logic [DUTY_W-1:0] GAMMA_ROM [0:100] = '{
      16'd0,     16'd32,    16'd101,   16'd197,   16'd318,   16'd460,   16'd622,
      16'd803,   16'd1001,  16'd1217,  16'd1449,  16'd1697,  16'd1960,  16'd2237,
      16'd2529,  16'd2835,  16'd3155,  16'd3488,  16'd3834,  16'd4193,  16'd4565,
      16'd4949,  16'd5345,  16'd5753,  16'd6173,  16'd6604,  16'd7047,  16'd7502,
      16'd7967,  16'd8444,  16'd8931,  16'd9429,  16'd9938,  16'd10457, 16'd10987,
      16'd11527, 16'd12077, 16'd12638, 16'd13208, 16'd13789, 16'd14379, 16'd14979,
      16'd15588, 16'd16208, 16'd16836, 16'd17474, 16'd18122, 16'd18779, 16'd19445,
      16'd20120, 16'd20804, 16'd21497, 16'd22200, 16'd22911, 16'd23631, 16'd24360,
      16'd25097, 16'd25843, 16'd26598, 16'd27362, 16'd28134, 16'd28914, 16'd29703,
      16'd30500, 16'd31306, 16'd32120, 16'd32942, 16'd33772, 16'd34611, 16'd35457,
      16'd36312, 16'd37175, 16'd38045, 16'd38924, 16'd39811, 16'd40705, 16'd41608,
      16'd42518, 16'd43436, 16'd44361, 16'd45295, 16'd46236, 16'd47185, 16'd48141,
      16'd49105, 16'd50076, 16'd51055, 16'd52042, 16'd53036, 16'd54037, 16'd55046,
      16'd56062, 16'd57086, 16'd58117, 16'd59155, 16'd60200, 16'd61253, 16'd62313,
      16'd63380, 16'd64454, 16'd65535
   };

   function automatic logic [DUTY_W-1:0] gamma_lookup(input logic [PCT_W-1:0] idx);
      logic [DUTY_W-1:0] g;
      if (idx > PCT_MAX) begin
         g = '0;
      end else begin
         g = GAMMA_ROM[idx];
      end
      return g;
   endfunction

endpackage

`default_nettype wire

@@ rtl/fpdm_muldiv.sv @@
`default_nettype none

// Multiply-add and constant divide in steps: numerator, then reciprocal
// product (/100) or high-half fold (/65535), then shift or 0..2 correction.
module fpdm_muldiv (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fpdm_pkg::div_cmd_type cmd,
   output fpdm_pkg::div_rsp_type      rsp
);

   localparam int DW  = fpdm_pkg::DUTY_W;
   localparam int NW  = fpdm_pkg::PCT_NUM_W;
   localparam int PRW = fpdm_pkg::PCT_NUM_W + fpdm_pkg::RECIP_W;

   logic           ph1_ff, ph1_in;
   logic           ph2_ff, ph2_in;
   logic           full_ff, full_in;
   logic [31:0]    num_ff, num_in;
   logic [PRW-1:0] prod_ff, prod_in;
   logic [DW-1:0]  q0_ff, q0_in;
   logic [DW:0]    rem_ff, rem_in;
   logic [1:0]     corr;

   always_comb begin
      ph1_in  = cmd.start;
      ph2_in  = ph1_ff;
      full_in = cmd.start ? cmd.by_full : full_ff;
      num_in  = cmd.start ? 32'(cmd.a) * 32'(cmd.b) + 32'(cmd.addend) : num_ff;
      prod_in = num_ff[NW-1:0] * fpdm_pkg::RECIP_100;
      // x = q0 * 65536 + lo, so x - q0 * 65535 = lo + q0
      q0_in   = num_ff[31:16];
      rem_in  = {1'b0, num_ff[15:0]} + {1'b0, num_ff[31:16]};
      corr    = {1'b0, rem_ff >= fpdm_pkg::DIV_FULL_ONE}
              + {1'b0, rem_ff >= fpdm_pkg::DIV_FULL_TWO};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph1_ff <= 1'b0;
         ph2_ff <= 1'b0;
      end else begin
         ph1_ff <= ph1_in;
         ph2_ff <= ph2_in;
      end
   end

   always_ff @(posedge clock) begin
      full_ff <= full_in;
      num_ff  <= num_in;
      prod_ff <= prod_in;
      q0_ff   <= q0_in;
      rem_ff  <= rem_in;
   end

   assign rsp.done     = ph2_ff;
   assign rsp.quotient = full_ff ? q0_ff + DW'(corr)
                                 : prod_ff[fpdm_pkg::RECIP_SHIFT +: DW];

endmodule

`default_nettype wire

@@ rtl/frontlight_pwm_duty_mixer.sv @@
`default_nettype none

// Steps in the shared unit: linear single, cool duty; linear dual, cool and warm
// percent then cool and warm duty; perceptual single, gamma; dual, gamma then split.
// Step: multiply-add, then reciprocal product or 16-bit fold, then shift or correct.
// One item at a time: req_stall is high from accept until the result is taken, so
// a new command waits until the result for the last one has been taken.
// Synchronous active-high reset: brightness 0, mix 0, remembered 100, pwm_bits 10.
module frontlight_pwm_duty_mixer #(
   parameter int MAX_PWM_BITS = fpdm_pkg::MAX_PWM_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [7:0]  req_value,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_cool_duty,
   output logic [15:0]      rsp_warm_duty,
   output logic             rsp_warm_driven,

   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int PW = fpdm_pkg::PCT_W;
   localparam int DW = fpdm_pkg::DUTY_W;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [4:0] pwm_bits_ff, pwm_bits_in;
   logic       active_high_ff, active_high_in;
   logic       dual_ff, dual_in;
   logic       percep_ff, percep_in;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      pwm_bits_in    = pwm_bits_ff;
      active_high_in = active_high_ff;
      dual_in        = dual_ff;
      percep_in      = percep_ff;
      if (csr_write) begin
         case (paddr[3:2])
            fpdm_pkg::CSR_PWM_BITS:     pwm_bits_in    = pwdata[4:0];
            fpdm_pkg::CSR_ACTIVE_HIGH:  active_high_in = pwdata[0];
            fpdm_pkg::CSR_DUAL_CHANNEL: dual_in        = pwdata[0];
            fpdm_pkg::CSR_PERCEPTUAL:   percep_in      = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         fpdm_pkg::CSR_PWM_BITS:     prdata = {27'd0, pwm_bits_ff};
         fpdm_pkg::CSR_ACTIVE_HIGH:  prdata = {31'd0, active_high_ff};
         fpdm_pkg::CSR_DUAL_CHANNEL: prdata = {31'd0, dual_ff};
         fpdm_pkg::CSR_PERCEPTUAL:   prdata = {31'd0, percep_ff};
         default:                    prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Full scale: 2^bits - 1, bits clamped to 1..MAX_PWM_BITS
   // ---------------------------------------------------------------------
   logic [4:0]              bits_eff;
   logic [MAX_PWM_BITS:0]   one_shl;
   logic [MAX_PWM_BITS-1:0] full_scale;
   logic [DW-1:0]           full16;

   always_comb begin
      if (pwm_bits_ff == 5'd0) begin
         bits_eff = 5'd1;
      end else if (pwm_bits_ff > 5'(MAX_PWM_BITS)) begin
         bits_eff = 5'(MAX_PWM_BITS);
      end else begin
         bits_eff = pwm_bits_ff;
      end
      one_shl    = (MAX_PWM_BITS + 1)'(1) << bits_eff;
      full_scale = MAX_PWM_BITS'(one_shl - (MAX_PWM_BITS + 1)'(1));
      full16     = DW'(full_scale);
   end

   // ---------------------------------------------------------------------
   // Sequencer and datapath registers
   // ---------------------------------------------------------------------
   fpdm_pkg::fpdm_state_type state_ff, state_in;
   logic          launch_ff, launch_in;
   logic [PW-1:0] bright_ff, bright_in;
   logic [PW-1:0] mix_ff, mix_in;
   logic [PW-1:0] remem_ff, remem_in;
   logic [PW-1:0] cool_pct_ff, cool_pct_in;
   logic [PW-1:0] warm_pct_ff, warm_pct_in;
   logic [DW-1:0] cool_ff, cool_in;
   logic [DW-1:0] warm_ff, warm_in;

   fpdm_pkg::div_cmd_type div_cmd;
   fpdm_pkg::div_rsp_type div_rsp;

   logic          req_accept;
   logic          rsp_accept;
   logic          computing;
   logic [PW-1:0] val_clamped;
   logic [DW-1:0] gamma_total;

   assign req_stall  = (state_ff != fpdm_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (state_ff == fpdm_pkg::ST_DONE);
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign computing  = (state_ff != fpdm_pkg::ST_IDLE) && (state_ff != fpdm_pkg::ST_DONE);

   assign val_clamped = (req_value > 8'(fpdm_pkg::PCT_MAX)) ? fpdm_pkg::PCT_MAX
                                                           : req_value[PW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fpdm_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (percep_ff) begin
                  state_in = fpdm_pkg::ST_GAMMA;
               end else if (dual_ff) begin
                  state_in = fpdm_pkg::ST_PCT_COOL;
               end else begin
                  state_in = fpdm_pkg::ST_DUTY_COOL;
               end
            end
         end
         fpdm_pkg::ST_PCT_COOL: begin
            if (div_rsp.done) state_in = fpdm_pkg::ST_PCT_WARM;
         end
         fpdm_pkg::ST_PCT_WARM: begin
            if (div_rsp.done) state_in = fpdm_pkg::ST_DUTY_COOL;
         end
         fpdm_pkg::ST_DUTY_COOL: begin
            if (div_rsp.done) begin
               state_in = dual_ff ? fpdm_pkg::ST_DUTY_WARM : fpdm_pkg::ST_DONE;
            end
         end
         fpdm_pkg::ST_DUTY_WARM: begin
            if (div_rsp.done) state_in = fpdm_pkg::ST_DONE;
         end
         fpdm_pkg::ST_GAMMA: begin
            if (div_rsp.done) begin
               state_in = dual_ff ? fpdm_pkg::ST_SPLIT : fpdm_pkg::ST_DONE;
            end
         end
         fpdm_pkg::ST_SPLIT: begin
            if (div_rsp.done) state_in = fpdm_pkg::ST_DONE;
         end
         fpdm_pkg::ST_DONE: begin
            if (rsp_accept) state_in = fpdm_pkg::ST_IDLE;
         end
         default: state_in = fpdm_pkg::ST_IDLE;
      endcase
   end

   // Total duty from the gamma step; nonzero brightness never rounds to 0.
   always_comb begin
      if (bright_ff == '0) begin
         gamma_total = '0;
      end else if (div_rsp.quotient == '0) begin
         gamma_total = DW'(1);
      end else begin
         gamma_total = div_rsp.quotient;
      end
   end

   // outputs: unit operands and datapath updates
   always_comb begin
      bright_in   = bright_ff;
      mix_in      = mix_ff;
      remem_in    = remem_ff;
      cool_pct_in = cool_pct_ff;
      warm_pct_in = warm_pct_ff;
      cool_in     = cool_ff;
      warm_in     = warm_ff;

      div_cmd.start   = computing && !launch_ff;
      div_cmd.by_full = 1'b0;
      div_cmd.a       = '0;
      div_cmd.b       = '0;
      div_cmd.addend  = '0;

      if (!computing) begin
         launch_in = 1'b0;
      end else if (div_rsp.done) begin
         launch_in = 1'b0;
      end else begin
         launch_in = 1'b1;
      end

      case (state_ff)
         fpdm_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_opcode)
                  fpdm_pkg::OP_SET_BRIGHT: begin
                     bright_in = val_clamped;
                     if (val_clamped != '0) remem_in = val_clamped;
                  end
                  fpdm_pkg::OP_SET_MIX: mix_in    = val_clamped;
                  fpdm_pkg::OP_OFF:     bright_in = '0;
                  fpdm_pkg::OP_ON:      bright_in = remem_ff;
                  default: ;
               endcase
               // single channel, linear: cool percent is the brightness itself
               cool_pct_in = bright_in;
            end
         end
         fpdm_pkg::ST_PCT_COOL: begin
            div_cmd.a = DW'(bright_ff);
            div_cmd.b = DW'(fpdm_pkg::PCT_MAX - mix_ff);
            if (div_rsp.done) cool_pct_in = PW'(div_rsp.quotient);
         end
         fpdm_pkg::ST_PCT_WARM: begin
            div_cmd.a = DW'(bright_ff);
            div_cmd.b = DW'(mix_ff);
            if (div_rsp.done) warm_pct_in = PW'(div_rsp.quotient);
         end
         fpdm_pkg::ST_DUTY_COOL: begin
            div_cmd.a = DW'(cool_pct_ff);
            div_cmd.b = full16;
            if (div_rsp.done) cool_in = div_rsp.quotient;
         end
         fpdm_pkg::ST_DUTY_WARM: begin
            div_cmd.a = DW'(warm_pct_ff);
            div_cmd.b = full16;
            if (div_rsp.done) warm_in = div_rsp.quotient;
         end
         fpdm_pkg::ST_GAMMA: begin
            div_cmd.a       = full16;
            div_cmd.b       = fpdm_pkg::gamma_lookup(bright_ff);
            div_cmd.addend  = fpdm_pkg::ROUND_GAMMA;
            div_cmd.by_full = 1'b1;
            if (div_rsp.done) begin
               cool_in = gamma_total;
               warm_in = '0;
            end
         end
         fpdm_pkg::ST_SPLIT: begin
            // warm gets the rounded share of the total, cool the rest
            div_cmd.a      = cool_ff;
            div_cmd.b      = DW'(mix_ff);
            div_cmd.addend = fpdm_pkg::ROUND_PCT;
            if (div_rsp.done) begin
               warm_in = div_rsp.quotient;
               cool_in = cool_ff - div_rsp.quotient;
            end
         end
         fpdm_pkg::ST_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= fpdm_pkg::ST_IDLE;
         launch_ff      <= 1'b0;
         bright_ff      <= '0;
         mix_ff         <= '0;
         remem_ff       <= fpdm_pkg::REMEMBERED_RST;
         pwm_bits_ff    <= fpdm_pkg::PWM_BITS_RST;
         active_high_ff <= 1'b1;
         dual_ff        <= 1'b0;
         percep_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         launch_ff      <= launch_in;
         bright_ff      <= bright_in;
         mix_ff         <= mix_in;
         remem_ff       <= remem_in;
         pwm_bits_ff    <= pwm_bits_in;
         active_high_ff <= active_high_in;
         dual_ff        <= dual_in;
         percep_ff      <= percep_in;
      end
   end

   always_ff @(posedge clock) begin
      cool_pct_ff <= cool_pct_in;
      warm_pct_ff <= warm_pct_in;
      cool_ff     <= cool_in;
      warm_ff     <= warm_in;
   end

   // Shared multiply-add / divide unit
   fpdm_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   // ---------------------------------------------------------------------
   // Result: active-low LEDs get full scale minus duty; warm is 0 when absent
   // ---------------------------------------------------------------------
   assign rsp_cool_duty   = active_high_ff ? cool_ff : full16 - cool_ff;
   assign rsp_warm_duty   = !dual_ff       ? '0
                          : active_high_ff ? warm_ff : full16 - warm_ff;
   assign rsp_warm_driven = dual_ff;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Run limits. Worst item: its pass through the block, the longest response
   // stall and the longest sender gap, for ~875 commands, plus register
   // phases. The limit is several times that.
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int ITEMS_PER_PHASE = 85;
   localparam int NUM_PHASES      = 10;
   localparam int SETTLE_CYCLES   = 100;   // above the worst latency

   // Perceptual curve, exponent 1.6554, 0..100 percent onto 0..65535.
   localparam logic [15:0] GAMMA_LUT [0:100] = '{
      16'd0,     16'd32,    16'd101,   16'd197,   16'd318,   16'd460,   16'd622,
      16'd803,   16'd1001,  16'd1217,  16'd1449,  16'd1697,  16'd1960,  16'd2237,
      16'd2529,  16'd2835,  16'd3155,  16'd3488,  16'd3834,  16'd4193,  16'd4565,
      16'd4949,  16'd5345,  16'd5753,  16'd6173,  16'd6604,  16'd7047,  16'd7502,
      16'd7967,  16'd8444,  16'd8931,  16'd9429,  16'd9938,  16'd10457, 16'd10987,
      16'd11527, 16'd12077, 16'd12638, 16'd13208, 16'd13789, 16'd14379, 16'd14979,
      16'd15588, 16'd16208, 16'd16836, 16'd17474, 16'd18122, 16'd18779, 16'd19445,
      16'd20120, 16'd20804, 16'd21497, 16'd22200, 16'd22911, 16'd23631, 16'd24360,
      16'd25097, 16'd25843, 16'd26598, 16'd27362, 16'd28134, 16'd28914, 16'd29703,
      16'd30500, 16'd31306, 16'd32120, 16'd32942, 16'd33772, 16'd34611, 16'd35457,
      16'd36312, 16'd37175, 16'd38045, 16'd38924, 16'd39811, 16'd40705, 16'd41608,
      16'd42518, 16'd43436, 16'd44361, 16'd45295, 16'd46236, 16'd47185, 16'd48141,
      16'd49105, 16'd50076, 16'd51055, 16'd52042, 16'd53036, 16'd54037, 16'd55046,
      16'd56062, 16'd57086, 16'd58117, 16'd59155, 16'd60200, 16'd61253, 16'd62313,
      16'd63380, 16'd64454, 16'd65535
   };

   typedef struct packed {
      logic [15:0] cool;
      logic [15:0] warm;
      logic        driven;
   } duty_result_type;

   // Duty predictor plus queue of expected duties, oldest first.
   class duty_scoreboard_type;
      logic [4:0]      pwm_bits;
      bit              active_high;
      bit              dual_channel;
      bit              perceptual;
      logic [6:0]      brightness;
      logic [6:0]      warm_mix;
      logic [6:0]      remembered;
      duty_result_type expected_duty_q [$];
      int              mismatches;
      int              commands;
      int              checked;

      function new();
         pwm_bits     = fpdm_pkg::PWM_BITS_RST;
         active_high  = 1'b1;
         dual_channel = 1'b0;
         perceptual   = 1'b0;
         brightness   = '0;
         warm_mix     = '0;
         remembered   = fpdm_pkg::REMEMBERED_RST;
         mismatches   = 0;
         commands     = 0;
         checked      = 0;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("MISMATCH: %s", msg);
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] data);
         case (idx)
            fpdm_pkg::CSR_PWM_BITS:     pwm_bits     = data[4:0];
            fpdm_pkg::CSR_ACTIVE_HIGH:  active_high  = data[0];
            fpdm_pkg::CSR_DUAL_CHANNEL: dual_channel = data[0];
            default:                    perceptual   = data[0];
         endcase
      endfunction

      function int pending();
         return expected_duty_q.size();
      endfunction

      function void note_command(logic [1:0] op, logic [7:0] raw);
         logic [6:0]      pct;
         int unsigned     res;
         longint unsigned full, br, mx, tot, cool, warm, cool_pct, warm_pct;
         duty_result_type exp_duty;
         pct = (raw > 8'd100) ? fpdm_pkg::PCT_MAX : raw[6:0];
         case (op)
            fpdm_pkg::OP_SET_BRIGHT: begin
               brightness = pct;
               if (pct != 0) remembered = pct;   // zero keeps the last level
            end
            fpdm_pkg::OP_SET_MIX: warm_mix = pct;
            fpdm_pkg::OP_OFF:     brightness = '0;
            default:              brightness = remembered;
         endcase
         res = pwm_bits;
         if (res < 1) res = 1;
         if (res > 16) res = 16;
         full = (64'd1 << res) - 1;
         br   = brightness;
         mx   = warm_mix;
         if (perceptual) begin
            // total duty from the curve, rounded, never 0 when lit
            tot = 0;
            if (br > 0) begin
               tot = (full * GAMMA_LUT[br] + 32767) / 65535;
               if (tot == 0) tot = 1;
            end
            warm = dual_channel ? (tot * mx + 50) / 100 : 0;
            cool = tot - warm;
         end else begin
            // split percent first, then scale with truncation
            cool_pct = dual_channel ? (br * (100 - mx)) / 100 : br;
            warm_pct = (br * mx) / 100;
            cool     = (cool_pct * full) / 100;
            warm     = (warm_pct * full) / 100;
         end
         if (!active_high) begin
            cool = full - cool;
            warm = full - warm;
         end
         exp_duty.cool   = cool[15:0];
         exp_duty.warm   = dual_channel ? warm[15:0] : 16'd0;
         exp_duty.driven = dual_channel;
         expected_duty_q.push_back(exp_duty);
         commands++;
      endfunction

      function void check_duty(logic [15:0] cool, logic [15:0] warm, logic driven);
         duty_result_type exp_duty;
         if (expected_duty_q.size() == 0) begin
            flag($sformatf("result cool=%0d warm=%0d driven=%0b with no command pending",
                           cool, warm, driven));
            return;
         end
         exp_duty = expected_duty_q.pop_front();
         checked++;
         if (cool !== exp_duty.cool || warm !== exp_duty.warm || driven !== exp_duty.driven)
            flag($sformatf({"result %0d: expected cool=%0d warm=%0d driven=%0b, ",
                            "got cool=%0d warm=%0d driven=%0b"},
                           checked, exp_duty.cool, exp_duty.warm, exp_duty.driven,
                           cool, warm, driven));
      endfunction
   endclass

   // DUT signals; every input starts at a known value
   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode      = fpdm_pkg::OP_OFF;
   logic [7:0]  req_value       = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [15:0] rsp_cool_duty;
   logic [15:0] rsp_warm_duty;
   logic        rsp_warm_driven;
   logic        psel            = 1'b0;
   logic        penable         = 1'b0;
   logic        pwrite          = 1'b0;
   logic [3:0]  paddr           = 4'd0;
   logic [31:0] pwdata          = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   duty_scoreboard_type sb = new();

   bit          quiet_phase = 1'b0;  // no idling on either side
   int          stall_left  = 0;
   int unsigned stall_roll;
   int unsigned cycle_count = 0;
   int          settings    = 0;

   // Directed commands: first 12 with reset registers (linear, single),
   // last 12 at 16 bits, dual channel, perceptual curve.
   logic [1:0] dir_ops [0:23] = '{
      fpdm_pkg::OP_ON, fpdm_pkg::OP_SET_BRIGHT, fpdm_pkg::OP_ON,
      fpdm_pkg::OP_SET_BRIGHT, fpdm_pkg::OP_SET_BRIGHT, fpdm_pkg::OP_SET_MIX,
      fpdm_pkg::OP_SET_BRIGHT, fpdm_pkg::OP_OFF, fpdm_pkg::OP_ON,
      fpdm_pkg::OP_SET_BRIGHT, fpdm_pkg::OP_SET_MIX, fpdm_pkg::OP_SET_BRIGHT,
      fpdm_pkg::OP_SET_MIX, fpdm_pkg::OP_SET_BRIGHT, fpdm_pkg::OP_SET_BRIGHT,
      fpdm_pkg::OP_SET_MIX, fpdm_pkg::OP_SET_MIX, fpdm_pkg::OP_SET_BRIGHT,
      fpdm_pkg::OP_OFF, fpdm_pkg::OP_ON, fpdm_pkg::OP_SET_MIX,
      fpdm_pkg::OP_SET_BRIGHT, fpdm_pkg::OP_ON, fpdm_pkg::OP_SET_BRIGHT
   };
   logic [7:0] dir_vals [0:23] = '{
      8'd0, 8'd0, 8'd77, 8'd255, 8'd101, 8'd60,
      8'd1, 8'd255, 8'd0, 8'd100, 8'd200, 8'd50,
      8'd0, 8'd1, 8'd100, 8'd100, 8'd50, 8'd255,
      8'd0, 8'd0, 8'd33, 8'd0, 8'd128, 8'd99
   };

   // Register settings per random phase; later phases draw at random.
   int unsigned cfg_bits [0:5] = '{16, 0, 1, 31, 17, 16};
   bit          cfg_ah   [0:5] = '{1, 0, 1, 0, 1, 0};
   bit          cfg_dual [0:5] = '{1, 1, 1, 0, 1, 1};
   bit          cfg_perc [0:5] = '{1, 0, 1, 1, 0, 1};

   frontlight_pwm_duty_mixer dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Monitor: note accepted commands, check accepted results.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_command(req_opcode, req_value);
         if (rsp_valid && !rsp_stall) sb.check_duty(rsp_cool_duty, rsp_warm_duty,
                                                    rsp_warm_driven);
      end
   end

   // Result-side backpressure: mostly free, short bursts, rare long holds.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (quiet_phase) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 70) begin
            rsp_stall <= 1'b0;
         end else if (stall_roll < 96) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 3);
         end else begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(10, 40);
         end
      end
   end

   function automatic int next_gap();
      int unsigned roll;
      if (quiet_phase) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [31:0] reg_mask(logic [1:0] idx);
      return (idx == fpdm_pkg::CSR_PWM_BITS) ? 32'h1F : 32'h1;
   endfunction

   // One command; valid stays high into the next item when the gap is 0.
   task automatic send_command(logic [1:0] op, logic [7:0] val);
      int gap;
      req_opcode <= op;
      req_value  <= val;
      req_valid  <= 1'b1;
      do @(posedge clock); while (req_stall);
      gap = next_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait for every expected result.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Setup then access; unused upper data bits carry noise.
   task automatic csr_write(logic [1:0] idx, logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= ($urandom & ~reg_mask(idx)) | (data & reg_mask(idx));
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      sb.set_reg(idx, data);
   endtask

   task automatic csr_read_check(logic [1:0] idx, logic [31:0] want);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== (want & reg_mask(idx)))
         sb.flag($sformatf("register %0d read back 0x%0h, expected 0x%0h",
                           idx, prdata, want & reg_mask(idx)));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Write all four registers, then read them back.
   task automatic set_config(int unsigned bits, bit ah, bit dual, bit perc);
      logic [31:0] vals [0:3];
      vals[fpdm_pkg::CSR_PWM_BITS]     = bits;
      vals[fpdm_pkg::CSR_ACTIVE_HIGH]  = {31'd0, ah};
      vals[fpdm_pkg::CSR_DUAL_CHANNEL] = {31'd0, dual};
      vals[fpdm_pkg::CSR_PERCEPTUAL]   = {31'd0, perc};
      for (int i = 0; i < 4; i++) csr_write(2'(i), vals[i]);
      for (int i = 0; i < 4; i++) csr_read_check(2'(i), vals[i]);
      settings++;
   endtask

   initial begin
      int unsigned roll;
      logic [1:0]  op;
      logic [7:0]  val;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset register values
      settings = 1;
      for (int i = 0; i < 12; i++) send_command(dir_ops[i], dir_vals[i]);
      wait_idle();

      // directed, full resolution gamma path with warm string
      set_config(16, 1'b1, 1'b1, 1'b1);
      for (int i = 12; i < 24; i++) send_command(dir_ops[i], dir_vals[i]);

      // random phases; each starts from an idle block
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         quiet_phase = (ph == 3) || (ph == 7);
         if (ph < 6)
            set_config(cfg_bits[ph], cfg_ah[ph], cfg_dual[ph], cfg_perc[ph]);
         else
            set_config($urandom_range(0, 31), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45)      op = fpdm_pkg::OP_SET_BRIGHT;
            else if (roll < 75) op = fpdm_pkg::OP_SET_MIX;
            else if (roll < 87) op = fpdm_pkg::OP_OFF;
            else                op = fpdm_pkg::OP_ON;
            roll = $urandom_range(0, 99);
            if (roll < 65)      val = 8'($urandom_range(0, 100));
            else if (roll < 80) val = 8'($urandom_range(101, 255));
            else begin
               case ($urandom_range(0, 5))
                  0:       val = 8'd0;
                  1:       val = 8'd1;
                  2:       val = 8'd99;
                  3:       val = 8'd100;
                  4:       val = 8'd128;
                  default: val = 8'd255;
               endcase
            end
            send_command(op, val);
         end
      end

      // drain, then let the block settle
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (sb.pending() != 0)
         sb.flag($sformatf("%0d expected results never arrived", sb.pending()));
      if (sb.mismatches > 10)
         $display("%0d mismatches in total, only the first 10 shown", sb.mismatches);

      $display("Sent %0d commands, checked %0d duty results over %0d register settings",
               sb.commands, sb.checked, settings);
      $display("Covered resolution 0/1/16/17/31, both polarities, one and two strings, "
               , "linear and gamma curves");
      if (sb.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
